FILE: sv/tkm_pkg.sv
// shared types, constants and helper functions for the touch-key midi block
`default_nettype none

package tkm_pkg;

    localparam int MAX_SEQ   = 32;
    localparam int SEQ_W     = 6;
    localparam int NUM_KEYS  = 14;
    localparam int KEY_W     = 4;
    localparam int KEY_ARP    = 11;
    localparam int KEY_OCT_DN = 12;
    localparam int KEY_OCT_UP = 13;
    localparam int CHORD_COUNT = 5;

    localparam logic [7:0] NOTE_ON  = 8'h90;
    localparam logic [7:0] NOTE_OFF = 8'h80;
    localparam logic [6:0] NOTE_MAX = 7'd127;
    localparam logic [7:0] OCT_STEP = 8'd12;

    // keys that can produce a note-on, and keys that can produce a note-off
    localparam logic [NUM_KEYS-1:0] ON_KEYS  = 14'h07FF;
    localparam logic [NUM_KEYS-1:0] OFF_KEYS = 14'h0FFF;

    localparam logic [6:0]  RST_BASE_NOTE   = 7'd48;
    localparam logic [6:0]  RST_VELOCITY    = 7'd127;
    localparam logic [5:0]  RST_OCT_LIMIT   = 6'd48;
    localparam logic [15:0] RST_STEP_PERIOD = 16'd286;
    localparam logic [6:0]  RST_ARP_ROOT    = 7'd48;
    localparam logic [2:0]  RST_ARP_CHORD   = 3'd4;
    localparam logic [7:0]  RST_ARP_CYCLES  = 8'd10;

    typedef enum logic [2:0] {
        CFG_BASE_NOTE   = 3'd0,
        CFG_VELOCITY    = 3'd1,
        CFG_OCT_LIMIT   = 3'd2,
        CFG_STEP_PERIOD = 3'd3,
        CFG_ARP_ROOT    = 3'd4,
        CFG_ARP_CHORD   = 3'd5,
        CFG_ARP_CYCLES  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CHD_MAJOR = 3'd0,
        CHD_MINOR = 3'd1,
        CHD_DIM   = 3'd2,
        CHD_AUG   = 3'd3,
        CHD_DOM7  = 3'd4
    } t_chord;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TICK,
        S_ARP_ON,
        S_ARP_OFF
    } t_state;

    typedef enum logic [1:0] {
        SRC_KEY,
        SRC_ARP_ON,
        SRC_ARP_OFF
    } t_src;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic tick;
        logic out_load;
        t_src src;
    } t_cmd;

    typedef struct packed {
        logic in_tick;
        logic key_emit;
        logic key_final;
        logic out_free;
        logic step_go;
    } t_stat;

    function automatic logic [2:0] chord_size(input logic [2:0] chord);
        return (chord == CHD_DOM7) ? 3'd4 : 3'd3;
    endfunction

    function automatic logic [3:0] chord_interval(input logic [2:0] chord,
                                                  input logic [1:0] phase);
        logic [3:0] iv;
        iv = 4'd0;
        unique case (phase)
            2'd0: iv = 4'd0;
            2'd1: iv = (chord == CHD_MAJOR || chord == CHD_AUG ||
                        chord == CHD_DOM7) ? 4'd4 : 4'd3;
            2'd2: iv = (chord == CHD_DIM) ? 4'd6 :
                       (chord == CHD_AUG) ? 4'd8 : 4'd7;
            2'd3: iv = (chord == CHD_DOM7) ? 4'd10 : 4'd0;
            default: iv = 4'd0;
        endcase
        return iv;
    endfunction

    // remainder by three via base-four digit sum
    function automatic logic [1:0] mod3(input logic [SEQ_W-1:0] x);
        logic [3:0] s;
        s = {2'b00, x[1:0]} + {2'b00, x[3:2]} + {2'b00, x[5:4]};
        if (s >= 4'd6) s = s - 4'd6;
        if (s >= 4'd3) s = s - 4'd3;
        return s[1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/tkm_ctrl.sv
// sequencing state machine: key scan, tick evaluation and arpeggio step
`default_nettype none

module tkm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tkm_pkg::t_stat i_stat,
    output tkm_pkg::t_cmd      o_cmd
);
    import tkm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '{load: 1'b0, scan_step: 1'b0, tick: 1'b0,
                       out_load: 1'b0, src: SRC_KEY};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.in_tick ? S_TICK : S_SCAN;
                end
            end
            S_SCAN: begin
                // stall only when this key has a message and the output is full
                if (!i_stat.key_emit || i_stat.out_free) begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.out_load  = i_stat.key_emit;
                    o_cmd.src       = SRC_KEY;
                    if (i_stat.key_final) n_state = S_IDLE;
                end
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
                n_state    = i_stat.step_go ? S_ARP_ON : S_IDLE;
            end
            S_ARP_ON: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.src      = SRC_ARP_ON;
                    n_state        = S_ARP_OFF;
                end
            end
            S_ARP_OFF: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.src      = SRC_ARP_OFF;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/tkm_datapath.sv
// registers, key state, arpeggio sequence state and the output register
`default_nettype none

module tkm_datapath (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_opcode,
    input  wire logic [13:0] i_touch_mask,
    input  wire logic        i_out_ready,
    input  wire tkm_pkg::t_cmd i_cmd,
    output tkm_pkg::t_stat   o_stat,
    output logic             o_out_valid,
    output logic             o_msg_valid,
    output logic [7:0]       o_status_byte,
    output logic [6:0]       o_note,
    output logic [6:0]       o_velocity,
    output logic             o_last,
    output logic             o_led_on
);
    import tkm_pkg::*;

    // configuration
    logic [6:0]  r_base_note;
    logic [6:0]  r_velocity;
    logic [5:0]  r_oct_limit;
    logic [15:0] r_step_period;
    logic [6:0]  r_arp_root;
    logic [2:0]  r_arp_chord;
    logic [7:0]  r_arp_cycles;

    // block state
    logic [NUM_KEYS-1:0] r_held, n_held;
    logic [NUM_KEYS-1:0] r_pressed, n_pressed;
    logic [NUM_KEYS-1:0] r_released, n_released;
    logic [KEY_W-1:0]    r_key, n_key;
    logic signed [6:0]   r_shift, n_shift;
    logic                r_playing, n_playing;
    logic [SEQ_W-1:0]    r_pos, n_pos;
    logic [SEQ_W-1:0]    r_len, n_len;
    logic [15:0]         r_timer, n_timer;
    logic [6:0]          r_seq_root, n_seq_root;
    logic [2:0]          r_seq_chord, n_seq_chord;

    // output register
    logic       r_out_valid;
    logic [7:0] r_status;
    logic [6:0] r_note;
    logic [6:0] r_vel;
    logic       r_last;
    logic       r_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_note   <= RST_BASE_NOTE;
            r_velocity    <= RST_VELOCITY;
            r_oct_limit   <= RST_OCT_LIMIT;
            r_step_period <= RST_STEP_PERIOD;
            r_arp_root    <= RST_ARP_ROOT;
            r_arp_chord   <= RST_ARP_CHORD;
            r_arp_cycles  <= RST_ARP_CYCLES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE_NOTE:   r_base_note   <= i_cfg_data[6:0];
                CFG_VELOCITY:    r_velocity    <= i_cfg_data[6:0];
                CFG_OCT_LIMIT:   r_oct_limit   <= i_cfg_data[5:0];
                CFG_STEP_PERIOD: r_step_period <= i_cfg_data;
                CFG_ARP_ROOT:    r_arp_root    <= i_cfg_data[6:0];
                CFG_ARP_CHORD:   r_arp_chord   <= i_cfg_data[2:0];
                CFG_ARP_CYCLES:  r_arp_cycles  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // per-key messages still to go in this scan
    logic [NUM_KEYS-1:0] emit_mask;
    logic [NUM_KEYS-1:0] emit_above;
    logic                key_last;
    assign emit_mask  = (r_pressed & ON_KEYS) | (r_released & OFF_KEYS);
    assign emit_above = emit_mask & (14'h3FFE << r_key);
    assign key_last   = (emit_above == '0);

    // key note: base + shift + key, clamped to 0..127
    logic signed [8:0] key_sum;
    logic [6:0]        key_note;
    assign key_sum = $signed({{2{r_shift[6]}}, r_shift}) + $signed({2'b00, r_base_note})
                   + $signed({5'b00000, r_key});
    always_comb begin
        if (key_sum[8]) begin
            key_note = 7'd0;
        end else if (key_sum[7]) begin
            key_note = NOTE_MAX;
        end else begin
            key_note = key_sum[6:0];
        end
    end

    // octave shift with saturation at the limit
    logic signed [7:0] shift_ext, lim_pos, lim_neg, shift_dn, shift_up;
    assign shift_ext = {r_shift[6], r_shift};
    assign lim_pos   = $signed({2'b00, r_oct_limit});
    assign lim_neg   = -lim_pos;
    assign shift_dn  = ((shift_ext - $signed(OCT_STEP)) < lim_neg) ? lim_neg
                                                                  : shift_ext - $signed(OCT_STEP);
    assign shift_up  = ((shift_ext + $signed(OCT_STEP)) > lim_pos) ? lim_pos
                                                                  : shift_ext + $signed(OCT_STEP);

    // new sequence length from chord and repetition count
    logic [9:0]       seq_prod;
    logic [SEQ_W-1:0] build_len;
    assign seq_prod = 10'(r_arp_cycles) * 10'(chord_size(r_arp_chord));
    always_comb begin
        if (r_arp_chord >= 3'(CHORD_COUNT)) begin
            build_len = '0;
        end else if (seq_prod > 10'(MAX_SEQ)) begin
            build_len = SEQ_W'(MAX_SEQ);
        end else begin
            build_len = seq_prod[SEQ_W-1:0];
        end
    end

    // step timer
    logic [15:0] timer_inc, period_eff;
    logic        step_hit, seq_ok;
    assign timer_inc  = (r_timer == 16'hFFFF) ? r_timer : r_timer + 16'd1;
    assign period_eff = (r_step_period == '0) ? 16'd1 : r_step_period;
    assign step_hit   = (timer_inc >= period_eff);
    assign seq_ok     = (r_len != '0) && (r_len <= SEQ_W'(MAX_SEQ)) && (r_pos < r_len);

    // sequence note at current or previous position, previous wraps to the end
    logic [SEQ_W-1:0] prev_pos, sel_pos, pos_inc;
    logic [1:0]       phase;
    logic [7:0]       seq_sum;
    logic [6:0]       seq_note;
    assign prev_pos = (r_pos == '0) ? r_len - 1'b1 : r_pos - 1'b1;
    assign sel_pos  = (i_cmd.src == SRC_ARP_OFF) ? prev_pos : r_pos;
    assign phase    = (r_seq_chord == CHD_DOM7) ? sel_pos[1:0] : mod3(sel_pos);
    assign seq_sum  = {1'b0, r_seq_root} + {4'b0000, chord_interval(r_seq_chord, phase)};
    assign seq_note = seq_sum[7] ? NOTE_MAX : seq_sum[6:0];
    assign pos_inc  = r_pos + 1'b1;

    always_comb begin
        n_held      = r_held;
        n_pressed   = r_pressed;
        n_released  = r_released;
        n_key       = r_key;
        n_shift     = r_shift;
        n_playing   = r_playing;
        n_pos       = r_pos;
        n_len       = r_len;
        n_timer     = r_timer;
        n_seq_root  = r_seq_root;
        n_seq_chord = r_seq_chord;

        if (i_cmd.load) begin
            n_key = '0;
            if (!i_opcode) begin
                n_held     = i_touch_mask;
                n_pressed  = i_touch_mask & ~r_held;
                n_released = r_held & ~i_touch_mask;
            end
        end

        if (i_cmd.scan_step) begin
            n_key = r_key + 1'b1;
            if (r_pressed[r_key]) begin
                if (r_key == KEY_W'(KEY_ARP)) begin
                    n_len       = build_len;
                    n_seq_root  = r_arp_root;
                    n_seq_chord = r_arp_chord;
                    if (build_len == '0) begin
                        n_playing = 1'b0;
                        n_pos     = '0;
                    end else begin
                        n_playing = 1'b1;
                        n_timer   = '0;
                        if (r_pos >= build_len) n_pos = '0;
                    end
                end else if (r_key == KEY_W'(KEY_OCT_DN)) begin
                    n_shift = shift_dn[6:0];
                end else if (r_key == KEY_W'(KEY_OCT_UP)) begin
                    n_shift = shift_up[6:0];
                end
            end
        end

        if (i_cmd.tick && r_playing) begin
            if (step_hit) begin
                n_timer = '0;
                if (!seq_ok) begin
                    n_playing = 1'b0;
                    n_pos     = '0;
                end
            end else begin
                n_timer = timer_inc;
            end
        end

        // advance after the note-off of a step
        if (i_cmd.out_load && i_cmd.src == SRC_ARP_OFF) begin
            if (pos_inc >= r_len) begin
                n_playing = 1'b0;
                n_pos     = '0;
            end else begin
                n_pos = pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_shift   <= '0;
            r_playing <= 1'b0;
            r_pos     <= '0;
            r_len     <= '0;
            r_timer   <= '0;
        end else begin
            r_held    <= n_held;
            r_shift   <= n_shift;
            r_playing <= n_playing;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_timer   <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pressed   <= n_pressed;
        r_released  <= n_released;
        r_key       <= n_key;
        r_seq_root  <= n_seq_root;
        r_seq_chord <= n_seq_chord;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_led <= (r_held != '0);
            unique case (i_cmd.src)
                SRC_KEY: begin
                    r_status <= r_pressed[r_key] ? NOTE_ON : NOTE_OFF;
                    r_note   <= key_note;
                    r_vel    <= r_pressed[r_key] ? r_velocity : 7'd0;
                    r_last   <= key_last;
                end
                SRC_ARP_ON: begin
                    r_status <= NOTE_ON;
                    r_note   <= seq_note;
                    r_vel    <= r_velocity;
                    r_last   <= 1'b0;
                end
                SRC_ARP_OFF: begin
                    r_status <= NOTE_OFF;
                    r_note   <= seq_note;
                    r_vel    <= 7'd0;
                    r_last   <= 1'b1;
                end
                default: begin
                    r_status <= NOTE_OFF;
                    r_note   <= seq_note;
                    r_vel    <= 7'd0;
                    r_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_stat.in_tick   = i_opcode;
    assign o_stat.key_emit  = emit_mask[r_key];
    assign o_stat.key_final = (r_key == KEY_W'(NUM_KEYS - 1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.step_go   = r_playing && step_hit && seq_ok;

    assign o_out_valid   = r_out_valid;
    assign o_msg_valid   = 1'b1;
    assign o_status_byte = r_status;
    assign o_note        = r_note;
    assign o_velocity    = r_vel;
    assign o_last        = r_last;
    assign o_led_on      = r_led;

endmodule

`default_nettype wire

FILE: sv/touch_keys_to_midi_with_arpeggio_top.sv
// touch mask update: accepted in the idle state, then all 14 keys are scanned, one key per cycle,
// messages leave through a single output register (scan stalls while it is full)
// tick: accepted in the idle state and evaluated in the tick state, then on a step the note-on and note-off states
// one request in flight at a time; a new one is taken while the last message waits
// reset: synchronous active low, clears keys, octave, playback and config to defaults
`default_nettype none

module touch_keys_to_midi_with_arpeggio_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_opcode,
    input  wire logic [13:0] i_touch_mask,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_msg_valid,
    output logic [7:0]       o_status_byte,
    output logic [6:0]       o_note,
    output logic [6:0]       o_velocity,
    output logic             o_last,
    output logic             o_led_on
);
    import tkm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    tkm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tkm_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_touch_mask  (i_touch_mask),
        .i_out_ready   (i_out_ready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_msg_valid   (o_msg_valid),
        .o_status_byte (o_status_byte),
        .o_note        (o_note),
        .o_velocity    (o_velocity),
        .o_last        (o_last),
        .o_led_on      (o_led_on)
    );

endmodule

`default_nettype wire
